### design/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

	localparam int ChanW = 8;
	localparam int FracW = 24;

	// Hue sector: six slices of the color wheel
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	// Candidate channel fractions, each an exact value over 2^24
	typedef struct packed {
		logic [FracW-1:0] vv;
		logic [FracW-1:0] pp;
		logic [FracW-1:0] qq;
		logic [FracW-1:0] tt;
	} frac_set_t;

	// floor(255 * x / 2^24), with 255 * x formed as 256 * x - x
	function automatic logic [ChanW-1:0] to_channel(input logic [FracW-1:0] x);
		logic [FracW+ChanW-1:0] prod;
		prod = {x, {ChanW{1'b0}}} - {{ChanW{1'b0}}, x};
		return prod[FracW+ChanW-1:FracW];
	endfunction

endpackage

### design/hsv2rgb_hsv_if.sv
interface hsv2rgb_hsv_if;
	logic       valid;
	logic       ready;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;

	modport source(output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink(input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

### design/hsv2rgb_rgb_if.sv
interface hsv2rgb_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, output red, output green, output blue, input ready);
	modport sink(input valid, input red, input green, input blue, output ready);
endinterface

### design/hsv_to_rgb_8bit_core.sv
// HSV to RGB pixel converter, four register stages.
// An accepted hsv word passes through stages s1, s2, s3 and s4 to the rgb output.
// Throughput: one pixel per cycle while rgb.ready is high; each stage holds one word and advances when
// the stage after it is empty or advancing, so a stall back-pressures cleanly.
// Reset (arst_n low) empties the pipeline by clearing the stage valid flags; the data registers are not reset.
module hsv_to_rgb_8bit_core (
	input  logic                 clk,
	input  logic                 arst_n,
	hsv2rgb_hsv_if.sink          hsv,
	hsv2rgb_rgb_if.source        rgb
);
	import hsv2rgb_pkg::*;

	// stage enables, back to front
	logic en_s1, en_s2, en_s3, en_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: sector and hue fraction
	logic [10:0] hue6;
	sector_t     sector_s1;
	logic [7:0]  fr_s1;
	logic [7:0]  sat_s1;
	logic [7:0]  val_s1;

	// stage 2: 8x9 products
	logic [8:0]  fr_c;
	logic [8:0]  sat_c;
	logic [16:0] sfc_full;
	logic [16:0] pp_full;
	logic [15:0] sf_s2;
	logic [15:0] sfc_s2;
	logic [15:0] pp_s2;
	logic [7:0]  val_s2;
	sector_t     sector_s2;

	// stage 3: value-scaled fractions
	logic [24:0] qq_full;
	logic [24:0] tt_full;
	frac_set_t   frac_s3;
	sector_t     sector_s3;

	// stage 4: permuted and scaled channels
	logic [7:0]  red_c, green_c, blue_c;
	logic [7:0]  red_s4, green_s4, blue_s4;

	assign en_s4 = !v_s4 || rgb.ready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign hsv.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= hsv.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// hue * 6 as two shifted adds; upper bits give the sector
	assign hue6 = {1'b0, hsv.hue, 2'b00} + {2'b00, hsv.hue, 1'b0};

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sector_s1 <= sector_t'(hue6[10:8]);
			fr_s1     <= hue6[7:0];
			sat_s1    <= hsv.saturation;
			val_s1    <= hsv.brightness;
		end
	end

	assign fr_c     = 9'd256 - {1'b0, fr_s1};
	assign sat_c    = 9'd256 - {1'b0, sat_s1};
	assign sfc_full = {9'd0, sat_s1} * {8'd0, fr_c};
	assign pp_full  = {9'd0, val_s1} * {8'd0, sat_c};

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sf_s2     <= {8'd0, sat_s1} * {8'd0, fr_s1};
			sfc_s2    <= sfc_full[15:0];
			pp_s2     <= pp_full[15:0];
			val_s2    <= val_s1;
			sector_s2 <= sector_s1;
		end
	end

	// results stay below 2^24, so the top bit of each product is always clear
	assign qq_full = {17'd0, val_s2} * (25'h0010000 - {9'd0, sf_s2});
	assign tt_full = {17'd0, val_s2} * (25'h0010000 - {9'd0, sfc_s2});

	always_ff @(posedge clk) begin
		if (en_s3) begin
			frac_s3.vv <= {val_s2, 16'd0};
			frac_s3.pp <= {pp_s2, 8'd0};
			frac_s3.qq <= qq_full[23:0];
			frac_s3.tt <= tt_full[23:0];
			sector_s3  <= sector_s2;
		end
	end

	hsv2rgb_perm u_perm (
		.sector (sector_s3),
		.frac   (frac_s3),
		.red    (red_c),
		.green  (green_c),
		.blue   (blue_c)
	);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			red_s4   <= red_c;
			green_s4 <= green_c;
			blue_s4  <= blue_c;
		end
	end

	assign rgb.valid = v_s4;
	assign rgb.red   = red_s4;
	assign rgb.green = green_s4;
	assign rgb.blue  = blue_s4;

endmodule

### design/hsv2rgb_perm.sv
module hsv2rgb_perm (
	input  hsv2rgb_pkg::sector_t   sector,
	input  hsv2rgb_pkg::frac_set_t frac,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue
);
	import hsv2rgb_pkg::*;

	logic [FracW-1:0] r24;
	logic [FracW-1:0] g24;
	logic [FracW-1:0] b24;

	always_comb begin
		case (sector)
			SEC_RED_YEL: begin
				r24 = frac.vv; g24 = frac.tt; b24 = frac.pp;
			end
			SEC_YEL_GRN: begin
				r24 = frac.qq; g24 = frac.vv; b24 = frac.pp;
			end
			SEC_GRN_CYN: begin
				r24 = frac.pp; g24 = frac.vv; b24 = frac.tt;
			end
			SEC_CYN_BLU: begin
				r24 = frac.pp; g24 = frac.qq; b24 = frac.vv;
			end
			SEC_BLU_MAG: begin
				r24 = frac.tt; g24 = frac.pp; b24 = frac.vv;
			end
			default: begin
				r24 = frac.vv; g24 = frac.pp; b24 = frac.qq;
			end
		endcase
	end

	assign red   = to_channel(r24);
	assign green = to_channel(g24);
	assign blue  = to_channel(b24);

endmodule

### design/hsv2rgb_chk.sv
module hsv2rgb_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_sat,
	input logic [7:0] in_val,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue
);

	// an empty output register means the whole pipe can advance
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output is empty");

	// with the sink ready, an accepted word moves through stages s1 to s4 and shows on the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("accepted word did not reach the output in time");

	// zero saturation gives grey at floor(255 * V / 256)
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_sat == 8'd0)
		##1 out_ready ##1 out_ready ##1 out_ready
		|=> (out_red == out_green && out_green == out_blue
			&& out_red == (($past(in_val, 4) == 8'd0) ? 8'd0 : $past(in_val, 4) - 8'd1)))
		else $error("grey pixel converted wrongly");

	// hold the output word while the sink stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red)
			&& $stable(out_green) && $stable(out_blue))
		else $error("output word changed under stall");

endmodule

bind hsv_to_rgb_8bit_core hsv2rgb_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (hsv.valid),
	.in_ready  (hsv.ready),
	.in_sat    (hsv.saturation),
	.in_val    (hsv.brightness),
	.out_valid (rgb.valid),
	.out_ready (rgb.ready),
	.out_red   (rgb.red),
	.out_green (rgb.green),
	.out_blue  (rgb.blue)
);

### verif/hsv_to_rgb_8bit_checker.sv
`timescale 1ns / 100ps

module hsv_to_rgb_8bit_checker (
	input  logic   clk,
	input  logic   arst_n,
	hsv2rgb_hsv_if hsv,
	hsv2rgb_rgb_if rgb,
	output int     pending,
	output int     errors
);
	import hsv2rgb_pkg::*;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} rgb_pixel_t;

	rgb_pixel_t expected_rgb[$];
	rgb_pixel_t want;

	// floor(255 * x / 2^24); x stays below 2^24, so the product fits in 32 bits
	function automatic logic [ChanW-1:0] frac_to_level(input logic [31:0] x);
		logic [39:0] prod;
		prod = 40'(x) * 40'd255;
		return prod[31:24];
	endfunction

	function automatic rgb_pixel_t convert_pixel(input logic [7:0] h, input logic [7:0] s,
		input logic [7:0] v);
		logic [10:0] h6;
		logic [31:0] fr;
		logic [31:0] vv, pp, qq, tt;
		logic [31:0] r_frac, g_frac, b_frac;
		rgb_pixel_t px;
		h6 = 11'(h) * 11'd6;
		fr = 32'(h6[7:0]);
		vv = 32'(v) << 16;
		pp = (32'(v) * (32'd256 - 32'(s))) << 8;
		qq = 32'(v) * (32'd65536 - 32'(s) * fr);
		tt = 32'(v) * (32'd65536 - 32'(s) * (32'd256 - fr));
		if (s == 8'd0) begin
			r_frac = vv;
			g_frac = vv;
			b_frac = vv;
		end else begin
			case (sector_t'(h6[10:8]))
				SEC_RED_YEL: begin
					r_frac = vv; g_frac = tt; b_frac = pp;
				end
				SEC_YEL_GRN: begin
					r_frac = qq; g_frac = vv; b_frac = pp;
				end
				SEC_GRN_CYN: begin
					r_frac = pp; g_frac = vv; b_frac = tt;
				end
				SEC_CYN_BLU: begin
					r_frac = pp; g_frac = qq; b_frac = vv;
				end
				SEC_BLU_MAG: begin
					r_frac = tt; g_frac = pp; b_frac = vv;
				end
				default: begin
					r_frac = vv; g_frac = pp; b_frac = qq;
				end
			endcase
		end
		px.red = frac_to_level(r_frac);
		px.green = frac_to_level(g_frac);
		px.blue = frac_to_level(b_frac);
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_rgb.delete();
			pending = 0;
		end else begin
			// retire the output word before queuing the new pixel
			if (rgb.valid && rgb.ready) begin
				if (expected_rgb.size() == 0) begin
					errors++;
					$error("unexpected rgb word: red %0d green %0d blue %0d",
						rgb.red, rgb.green, rgb.blue);
				end else begin
					want = expected_rgb.pop_front();
					if (rgb.red !== want.red) begin
						errors++;
						$error("red mismatch: expected %0d, actual %0d", want.red, rgb.red);
					end
					if (rgb.green !== want.green) begin
						errors++;
						$error("green mismatch: expected %0d, actual %0d", want.green, rgb.green);
					end
					if (rgb.blue !== want.blue) begin
						errors++;
						$error("blue mismatch: expected %0d, actual %0d", want.blue, rgb.blue);
					end
				end
			end
			if (hsv.valid && hsv.ready)
				expected_rgb.push_back(convert_pixel(hsv.hue, hsv.saturation, hsv.brightness));
			pending = expected_rgb.size();
		end
	end

endmodule

### verif/tb_hsv_to_rgb_8bit_core.sv
`timescale 1ns / 100ps

module tb_hsv_to_rgb_8bit_core;

	localparam int ResetCycles = 9;
	localparam int PhaseItems = 157;
	localparam int HoldCycles = 60;
	localparam int HoldItems = 20;
	localparam int DrainCycles = 10;
	localparam int CycleLimit = 200000;

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;
	bit   hold_req;
	int   pending;
	int   errors;
	int   cycle_count;

	hsv2rgb_hsv_if hsv ();
	hsv2rgb_rgb_if rgb ();

	hsv_to_rgb_8bit_core i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.hsv   (hsv),
		.rgb   (rgb)
	);

	hsv_to_rgb_8bit_checker i_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv),
		.rgb    (rgb),
		.pending(pending),
		.errors (errors)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Output side: random stalls, or a long hold-off on request
	initial begin
		rgb.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rgb.ready <= 1'b0;
				repeat (HoldCycles - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				rgb.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Call at a falling edge; returns at the falling edge after the word is taken
	task automatic send_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
		while ($urandom_range(0, 99) < idle_pct) begin
			hsv.valid <= 1'b0;
			@(negedge clk);
		end
		hsv.valid <= 1'b1;
		hsv.hue <= h;
		hsv.saturation <= s;
		hsv.brightness <= v;
		do @(posedge clk); while (!(hsv.valid && hsv.ready));
		@(negedge clk);
	endtask

	// Bias toward grey, full scale and black
	function automatic logic [7:0] pick_level();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++)
			send_pixel(8'($urandom_range(0, 255)), pick_level(), pick_level());
	endtask

	// Hold the input until every expected pixel has come out
	task automatic wait_empty();
		hsv.valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		hsv.valid = 1'b0;
		hsv.hue = 8'd0;
		hsv.saturation = 8'd0;
		hsv.brightness = 8'd0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		cycle_count = 0;
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes, grey, and both edges of every hue sector
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd77, 8'd0, 8'd255);
		send_pixel(8'd200, 8'd0, 8'd128);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd42, 8'd255, 8'd255);
		send_pixel(8'd43, 8'd255, 8'd255);
		send_pixel(8'd85, 8'd255, 8'd255);
		send_pixel(8'd86, 8'd255, 8'd255);
		send_pixel(8'd127, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd255, 8'd255);
		send_pixel(8'd170, 8'd255, 8'd255);
		send_pixel(8'd171, 8'd255, 8'd255);
		send_pixel(8'd213, 8'd255, 8'd255);
		send_pixel(8'd214, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd1, 8'd255);
		send_pixel(8'd20, 8'd128, 8'd200);
		send_pixel(8'd100, 8'd1, 8'd1);
		send_pixel(8'd150, 8'd255, 8'd0);
		send_pixel(8'd235, 8'd170, 8'd85);
		send_pixel(8'd64, 8'd255, 8'd1);
		wait_empty();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 58; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 58; end
				default: begin idle_pct = 19; stall_pct = 19; end
			endcase
			send_random(PhaseItems / 2);
			if (phase == 0 || phase == 3) begin
				// keep offering words while the output is held off, so the pipe backs up
				hold_req = 1'b1;
				send_random(HoldItems);
				send_random(PhaseItems - PhaseItems / 2 - HoldItems);
			end else begin
				send_random(PhaseItems - PhaseItems / 2);
			end
			wait_empty();
		end

		stall_pct = 0;
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
design/hsv2rgb_pkg.sv
design/hsv2rgb_hsv_if.sv
design/hsv2rgb_rgb_if.sv
design/hsv2rgb_perm.sv
design/hsv_to_rgb_8bit_core.sv
design/hsv2rgb_chk.sv
verif/hsv_to_rgb_8bit_checker.sv
verif/tb_hsv_to_rgb_8bit_core.sv
